// ===== rtl/core/assert_macros.svh =====
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, switched off while reset is held
`define SAR_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// clocked property that also holds during reset
`define SAR_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/core/sar_rb_pkg.sv =====
`timescale 1ns / 1ps

package sar_rb_pkg;

  // field and word widths
  localparam int IdxW    = 7;
  localparam int DataW   = 16;
  localparam int LevelW  = 10;
  localparam int CfgIdxW = 3;
  localparam int SlotW   = 3;

  // parameter defaults
  localparam int RegWordsDef    = 128;
  localparam int NumChannelsDef = 8;

  // word map
  localparam logic [IdxW-1:0] WordCtrl    = 7'd0;
  localparam logic [IdxW-1:0] WordMask    = 7'd20;
  localparam logic [IdxW-1:0] WordClr     = 7'd21;
  localparam logic [IdxW-1:0] WordForce   = 7'd22;
  localparam logic [IdxW-1:0] WordStatus  = 7'd23;
  localparam logic [IdxW-1:0] WordResult0 = 7'd64;

  // control and status bits
  localparam logic [DataW-1:0] CtrlChanMask = 16'h0007;
  localparam int CtrlStartBit = 7;
  localparam int CtrlLoadBit  = 14;
  localparam int DoneBit      = 0;

  localparam logic [LevelW-1:0] LevelReset = 10'd512;

  typedef enum logic {
    OpRead  = 1'b0,
    OpWrite = 1'b1
  } op_e;

  typedef logic [DataW-1:0]  word_t;
  typedef logic [LevelW-1:0] level_t;

  // one request as it leaves the input stage
  typedef struct packed {
    logic            fire;
    op_e             op;
    logic [IdxW-1:0] word_index;
    word_t           write_data;
  } access_t;

  // result words occupy one aligned group of eight
  function automatic logic is_result_word(logic [IdxW-1:0] idx);
    return idx[IdxW-1:SlotW] == WordResult0[IdxW-1:SlotW];
  endfunction

  // words kept in flops rather than in the word memory
  function automatic logic is_special(logic [IdxW-1:0] idx);
    return (idx == WordCtrl) || (idx == WordMask) || (idx == WordClr) ||
           (idx == WordForce) || (idx == WordStatus) || is_result_word(idx);
  endfunction

endpackage

// ===== rtl/core/sar_rb_req_if.sv =====
`timescale 1ns / 1ps

interface sar_rb_req_if;
  logic                         valid;
  logic                         ready;
  logic                         opcode;
  logic [sar_rb_pkg::IdxW-1:0]  word_index;
  logic [sar_rb_pkg::DataW-1:0] write_data;

  modport source (output valid, output opcode, output word_index, output write_data,
                  input ready);
  modport sink (input valid, input opcode, input word_index, input write_data,
                output ready);
endinterface

// ===== rtl/core/sar_rb_rsp_if.sv =====
`timescale 1ns / 1ps

interface sar_rb_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [sar_rb_pkg::DataW-1:0] read_data;
  logic                         irq_level;

  modport source (output valid, output read_data, output irq_level, input ready);
  modport sink (input valid, input read_data, input irq_level, output ready);
endinterface

// ===== rtl/core/sar_rb_levels.sv =====
`timescale 1ns / 1ps

module sar_rb_levels #(
  parameter int NUM_CHANNELS = sar_rb_pkg::NumChannelsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sar_rb_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  sar_rb_pkg::level_t             cfg_wdata_i,
  output sar_rb_pkg::level_t             levels_o [NUM_CHANNELS]
);

  sar_rb_pkg::level_t levels_q [NUM_CHANNELS];

  // per-channel conversion level, written through the config port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_CHANNELS; k++) begin
        levels_q[k] <= sar_rb_pkg::LevelReset;
      end
    end else if (cfg_we_i) begin
      for (int k = 0; k < NUM_CHANNELS; k++) begin
        if (cfg_idx_i == sar_rb_pkg::CfgIdxW'(k)) begin
          levels_q[k] <= cfg_wdata_i;
        end
      end
    end
  end

  assign levels_o = levels_q;

endmodule

// ===== rtl/core/sar_rb_mem.sv =====
`timescale 1ns / 1ps

module sar_rb_mem #(
  parameter int DEPTH = sar_rb_pkg::RegWordsDef,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  sar_rb_pkg::word_t wdata_i,
  input  logic              re_i,
  input  logic [AW-1:0]     raddr_i,
  output sar_rb_pkg::word_t rdata_o,
  output logic              rvalid_o
);

  sar_rb_pkg::word_t mem [DEPTH];
  logic [DEPTH-1:0]  written_q;
  sar_rb_pkg::word_t rdata_q;
  logic              rvalid_q;

  // word storage, no reset
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  // per-word written flags; an unwritten word reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
      rvalid_q  <= 1'b0;
    end else begin
      if (we_i) begin
        written_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rvalid_q <= written_q[raddr_i];
      end
    end
  end

  assign rdata_o  = rdata_q;
  assign rvalid_o = rvalid_q;

endmodule

// ===== rtl/core/sar_rb_spec.sv =====
`timescale 1ns / 1ps

module sar_rb_spec #(
  parameter int NUM_CHANNELS = sar_rb_pkg::NumChannelsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sar_rb_pkg::access_t acc_i,
  input  sar_rb_pkg::level_t  levels_i [NUM_CHANNELS],
  output sar_rb_pkg::word_t   rdata_o,
  output logic                irq_o
);

  localparam int Slots = 1 << sar_rb_pkg::SlotW;

  sar_rb_pkg::word_t ctrl_q, ctrl_d;
  sar_rb_pkg::word_t mask_q, mask_d;
  sar_rb_pkg::word_t force_q, force_d;
  sar_rb_pkg::word_t status_q, status_d;
  sar_rb_pkg::word_t result_q [Slots];
  sar_rb_pkg::word_t result_d [Slots];

  logic [sar_rb_pkg::SlotW-1:0] chan;
  logic                         conv;
  logic                         chan_ok;
  sar_rb_pkg::level_t           level_sel;
  sar_rb_pkg::word_t            wd;
  logic [sar_rb_pkg::IdxW-1:0]  idx;

  assign wd  = acc_i.write_data;
  assign idx = acc_i.word_index;

  // conversion request decode
  always_comb begin
    chan = sar_rb_pkg::SlotW'(wd & sar_rb_pkg::CtrlChanMask);
    conv = (wd[sar_rb_pkg::CtrlStartBit] && !ctrl_q[sar_rb_pkg::CtrlStartBit]) ||
           wd[sar_rb_pkg::CtrlLoadBit];
    chan_ok = (sar_rb_pkg::SlotW + 1)'(chan) < (sar_rb_pkg::SlotW + 1)'(NUM_CHANNELS);
    level_sel = '0;
    for (int k = 0; k < NUM_CHANNELS; k++) begin
      if (chan == sar_rb_pkg::SlotW'(k)) begin
        level_sel = levels_i[k];
      end
    end
  end

  // write side effects
  always_comb begin
    ctrl_d   = ctrl_q;
    mask_d   = mask_q;
    force_d  = force_q;
    status_d = status_q;
    result_d = result_q;
    if (acc_i.fire && acc_i.op == sar_rb_pkg::OpWrite) begin
      case (idx)
        sar_rb_pkg::WordCtrl: begin
          ctrl_d = wd;
          ctrl_d[sar_rb_pkg::CtrlLoadBit] = 1'b0;
          if (conv && chan_ok) begin
            result_d[chan] = sar_rb_pkg::DataW'(level_sel);
            status_d[sar_rb_pkg::DoneBit] = 1'b1;
          end
        end
        sar_rb_pkg::WordMask:   mask_d = wd;
        sar_rb_pkg::WordClr:    status_d = status_q & ~wd;
        sar_rb_pkg::WordForce: begin
          force_d  = wd;
          status_d = status_q | wd;
        end
        sar_rb_pkg::WordStatus: status_d = wd;
        default: begin
          if (sar_rb_pkg::is_result_word(idx)) begin
            result_d[idx[sar_rb_pkg::SlotW-1:0]] = wd;
          end
        end
      endcase
    end
  end

  // read mux; the clear word always reads zero
  always_comb begin
    case (idx)
      sar_rb_pkg::WordCtrl:   rdata_o = ctrl_q;
      sar_rb_pkg::WordMask:   rdata_o = mask_q;
      sar_rb_pkg::WordForce:  rdata_o = force_q;
      sar_rb_pkg::WordStatus: rdata_o = status_q;
      default: begin
        if (sar_rb_pkg::is_result_word(idx)) begin
          rdata_o = result_q[idx[sar_rb_pkg::SlotW-1:0]];
        end else begin
          rdata_o = '0;
        end
      end
    endcase
  end

  // interrupt after this access
  assign irq_o = |(status_d & ~mask_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q   <= '0;
      mask_q   <= '0;
      force_q  <= '0;
      status_q <= '0;
      for (int k = 0; k < Slots; k++) begin
        result_q[k] <= '0;
      end
    end else begin
      ctrl_q   <= ctrl_d;
      mask_q   <= mask_d;
      force_q  <= force_d;
      status_q <= status_d;
      result_q <= result_d;
    end
  end

endmodule

// ===== rtl/core/sar_adc_register_block.sv =====
`timescale 1ns / 1ps

// channel   dir  handshake       payload
// req       in   valid/ready     opcode, word_index, write_data
// rsp       out  valid/ready     read_data, irq_level
// cfg       in   cfg_we_i        cfg_idx_i, cfg_wdata_i (channel levels)
//
// one request per cycle unless rsp stalls; each request passes the input stage
// (with registered word-memory read) and then the response register
// control, status, mask, force and result words are flops; other words sit in
// a memory with per-word written flags, so reset takes effect at once
// a stalled response holds; one more request is taken behind it, then req stalls

module sar_adc_register_block #(
  parameter int REG_WORDS    = sar_rb_pkg::RegWordsDef,
  parameter int NUM_CHANNELS = sar_rb_pkg::NumChannelsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  sar_rb_req_if.sink                     req,
  sar_rb_rsp_if.source                   rsp,
  input  logic                           cfg_we_i,
  input  logic [sar_rb_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  sar_rb_pkg::level_t             cfg_wdata_i
);

  localparam int IdxSpan  = 1 << sar_rb_pkg::IdxW;
  localparam int MemDepth = (REG_WORDS < IdxSpan) ? REG_WORDS : IdxSpan;
  localparam int MemAw    = $clog2(MemDepth);

  // handshake control
  logic s1_valid_q, rsp_valid_q;
  logic out_take, s1_fire, accept;

  // input stage payload
  sar_rb_pkg::op_e             s1_op_q;
  logic [sar_rb_pkg::IdxW-1:0] s1_idx_q;
  sar_rb_pkg::word_t           s1_data_q;
  logic                        byp_hit_q;
  sar_rb_pkg::word_t           byp_data_q;

  // response payload
  sar_rb_pkg::word_t rsp_rdata_q;
  logic              rsp_irq_q;

  logic                s1_in_range, s1_special, mem_we, byp_hit_d;
  sar_rb_pkg::word_t   mem_rdata, spec_rdata, rdata_d;
  logic                mem_rvalid, spec_irq;
  sar_rb_pkg::access_t acc;
  sar_rb_pkg::level_t  levels [NUM_CHANNELS];

  assign out_take  = !rsp_valid_q || rsp.ready;
  assign s1_fire   = s1_valid_q && out_take;
  assign req.ready = !s1_valid_q || out_take;
  assign accept    = req.valid && req.ready;

  assign s1_in_range = 32'(s1_idx_q) < 32'(REG_WORDS);
  assign s1_special  = sar_rb_pkg::is_special(s1_idx_q);
  assign mem_we      = s1_fire && (s1_op_q == sar_rb_pkg::OpWrite) && s1_in_range &&
                       !s1_special;
  // forward a write that lands on the word the new request reads
  assign byp_hit_d   = mem_we && (s1_idx_q == req.word_index);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // input stage capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q    <= sar_rb_pkg::op_e'(req.opcode);
      s1_idx_q   <= req.word_index;
      s1_data_q  <= req.write_data;
      byp_hit_q  <= byp_hit_d;
      byp_data_q <= s1_data_q;
    end
  end

  sar_rb_levels #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_levels (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .levels_o   (levels)
  );

  sar_rb_mem #(
    .DEPTH(MemDepth),
    .AW   (MemAw)
  ) u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (mem_we),
    .waddr_i (s1_idx_q[MemAw-1:0]),
    .wdata_i (s1_data_q),
    .re_i    (accept),
    .raddr_i (req.word_index[MemAw-1:0]),
    .rdata_o (mem_rdata),
    .rvalid_o(mem_rvalid)
  );

  assign acc.fire       = s1_fire;
  assign acc.op         = s1_op_q;
  assign acc.word_index = s1_idx_q;
  assign acc.write_data = s1_data_q;

  sar_rb_spec #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_spec (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .acc_i   (acc),
    .levels_i(levels),
    .rdata_o (spec_rdata),
    .irq_o   (spec_irq)
  );

  // read data select; writes and out-of-bank reads return zero
  always_comb begin
    rdata_d = '0;
    if (s1_op_q == sar_rb_pkg::OpRead && s1_in_range) begin
      if (s1_special) begin
        rdata_d = spec_rdata;
      end else if (byp_hit_q) begin
        rdata_d = byp_data_q;
      end else if (mem_rvalid) begin
        rdata_d = mem_rdata;
      end
    end
  end

  // response register
  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      rsp_rdata_q <= rdata_d;
      rsp_irq_q   <= spec_irq;
    end
  end

  assign rsp.valid     = rsp_valid_q;
  assign rsp.read_data = rsp_rdata_q;
  assign rsp.irq_level = rsp_irq_q;

endmodule

// ===== rtl/core/sar_rb_chk.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sar_rb_chk (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         req_valid_i,
  input logic                         req_ready_i,
  input logic                         rsp_valid_i,
  input logic                         rsp_ready_i,
  input logic [sar_rb_pkg::DataW-1:0] rsp_read_data_i,
  input logic                         rsp_irq_level_i
);

  logic [1:0] inflight_q;
  logic       req_take, rsp_take;

  assign req_take = req_valid_i && req_ready_i;
  assign rsp_take = rsp_valid_i && rsp_ready_i;

  // requests taken but not yet answered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else if (req_take && !rsp_take) begin
      inflight_q <= inflight_q + 2'd1;
    end else if (rsp_take && !req_take) begin
      inflight_q <= inflight_q - 2'd1;
    end
  end

  `SAR_ASSERT(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_read_data_i) && $stable(rsp_irq_level_i), "stalled response changed")
  `SAR_ASSERT(a_no_backpressure, clk_i, rst_ni, req_valid_i && rsp_ready_i |-> req_ready_i, "request stalled with response side ready")
  `SAR_ASSERT(a_latency, clk_i, rst_ni, req_take ##1 rsp_ready_i |=> rsp_valid_i, "response late")
  `SAR_ASSERT(a_rsp_owed, clk_i, rst_ni, rsp_valid_i |-> inflight_q != 2'd0, "response without request")
  `SAR_ASSERT_ALWAYS(a_inflight_bound, clk_i, !rst_ni || inflight_q != 2'd3, "too many requests in flight")

endmodule

bind sar_adc_register_block sar_rb_chk u_sar_rb_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .req_valid_i    (req.valid),
  .req_ready_i    (req.ready),
  .rsp_valid_i    (rsp.valid),
  .rsp_ready_i    (rsp.ready),
  .rsp_read_data_i(rsp.read_data),
  .rsp_irq_level_i(rsp.irq_level)
);
